// File: hw/rtl/jdm_pkg.sv
// ----------------------------------------------------------------------------
// jdm_pkg: shared definitions for the joystick differential-drive mixer
// Field widths, region constants, job and arithmetic-unit structs, and the
// constant divisor and reciprocal tables.
// ----------------------------------------------------------------------------
package jdm_pkg;

  // Field widths of the command and drive channels.
  localparam int COORD_W = 12;
  localparam int SPEED_W = 7;
  localparam int MODE_W  = 4;
  localparam int DUTY_W  = 16;

  // Width of every intermediate coordinate and duty value (16-bit wrap).
  localparam int VAL_W = 16;

  // Default depth of the job queue between front and back.
  localparam int QUEUE_DEPTH = 2;

  // Joystick geometry.
  localparam int CENTRE    = 1024;
  localparam int DEAD_LO   = 819;
  localparam int DEAD_HI   = 1228;
  localparam int REMAP_LO  = 1229;
  localparam int FULL      = 2048;
  localparam int X_TOP_A   = 1536;
  localparam int REMAP_HI  = 1537;
  localparam int SLOPE_A   = X_TOP_A - REMAP_LO;   // 307
  localparam int SLOPE_B   = FULL - REMAP_HI;      // 511
  localparam int NX_OFFSET = REMAP_HI - CENTRE;    // 513
  localparam int DIVISOR   = 25;
  localparam int DEN_A     = FULL - REMAP_LO;      // 819
  localparam int DEN_B     = FULL - DEAD_HI;       // 820

  // Spin mode codes.
  localparam logic [MODE_W-1:0] MODE_SPIN_LEFT  = MODE_W'(1);
  localparam logic [MODE_W-1:0] MODE_STOP       = MODE_W'(2);
  localparam logic [MODE_W-1:0] MODE_SPIN_RIGHT = MODE_W'(3);

  // Job kinds produced by the classifier.
  localparam int KIND_W = 3;
  localparam logic [KIND_W-1:0] KIND_HOLD = 3'd0;  // outputs unchanged
  localparam logic [KIND_W-1:0] KIND_MIX  = 3'd1;  // two scaled duties
  localparam logic [KIND_W-1:0] KIND_TR_A = 3'd2;  // upper right, y at or above x
  localparam logic [KIND_W-1:0] KIND_TR_B = 3'd3;  // upper right, y below x
  localparam logic [KIND_W-1:0] KIND_TL_A = 3'd4;  // upper left, y above mirrored x
  localparam logic [KIND_W-1:0] KIND_TL_B = 3'd5;  // upper left, otherwise

  // Multiply-divide unit: q = (a * b) / d with d chosen by a code.
  localparam int MUL_B_W     = 9;
  localparam int P_W         = VAL_W + MUL_B_W;    // product width
  localparam int RECIP_SHIFT = P_W;
  localparam int RECIP_W     = 21;
  localparam int T_W         = P_W + RECIP_W;
  localparam int Q_W         = T_W - RECIP_SHIFT;
  localparam int DIV_W       = 10;
  localparam int DIVSEL_W    = 2;

  localparam logic [DIVSEL_W-1:0] DIV_BY_25  = 2'd0;
  localparam logic [DIVSEL_W-1:0] DIV_BY_819 = 2'd1;
  localparam logic [DIVSEL_W-1:0] DIV_BY_820 = 2'd2;

  localparam int RECIP_25  = (2 ** RECIP_SHIFT) / DIVISOR;
  localparam int RECIP_819 = (2 ** RECIP_SHIFT) / DEN_A;
  localparam int RECIP_820 = (2 ** RECIP_SHIFT) / DEN_B;

  // One classified command.
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic               dir_l;
    logic               dir_r;
    logic [SPEED_W-1:0] speed;
    logic [VAL_W-1:0]   op_a0;  // left value, or first remap operand
    logic [VAL_W-1:0]   op_a1;  // right value, or second remap operand
    logic [VAL_W-1:0]   base;   // offset applied after a single remap
    logic [VAL_W-1:0]   vy;     // y minus centre
  } job_t;

  typedef struct packed {
    logic                start;
    logic [VAL_W-1:0]    a;
    logic [MUL_B_W-1:0]  b;
    logic [DIVSEL_W-1:0] sel;
  } md_req_t;

  typedef struct packed {
    logic           done;
    logic [Q_W-1:0] q;
  } md_rsp_t;

  function automatic logic [DIV_W-1:0] div_const(input logic [DIVSEL_W-1:0] sel);
    logic [DIV_W-1:0] d;
    case (sel)
      DIV_BY_25:  d = DIV_W'(DIVISOR);
      DIV_BY_819: d = DIV_W'(DEN_A);
      DIV_BY_820: d = DIV_W'(DEN_B);
      default:    d = DIV_W'(DIVISOR);
    endcase
    return d;
  endfunction

  function automatic logic [RECIP_W-1:0] recip_const(input logic [DIVSEL_W-1:0] sel);
    logic [RECIP_W-1:0] m;
    case (sel)
      DIV_BY_25:  m = RECIP_W'(RECIP_25);
      DIV_BY_819: m = RECIP_W'(RECIP_819);
      DIV_BY_820: m = RECIP_W'(RECIP_820);
      default:    m = RECIP_W'(RECIP_25);
    endcase
    return m;
  endfunction

endpackage

// File: hw/rtl/jdm_if.sv
// ----------------------------------------------------------------------------
// jdm_if: command and drive channels
// Valid/ready channels carrying one joystick command and one drive request.
// ----------------------------------------------------------------------------
interface jdm_cmd_if;
  logic                          valid;
  logic                          ready;
  logic [jdm_pkg::COORD_W-1:0]   stick_x;
  logic [jdm_pkg::COORD_W-1:0]   stick_y;
  logic [jdm_pkg::SPEED_W-1:0]   speed;
  logic [jdm_pkg::MODE_W-1:0]    spin_mode;

  modport source (output valid, stick_x, stick_y, speed, spin_mode, input ready);
  modport sink (input valid, stick_x, stick_y, speed, spin_mode, output ready);
endinterface

interface jdm_drv_if;
  logic                        valid;
  logic                        ready;
  logic [jdm_pkg::DUTY_W-1:0]  duty_left;
  logic [jdm_pkg::DUTY_W-1:0]  duty_right;
  logic                        dir_left;
  logic                        dir_right;

  modport source (output valid, duty_left, duty_right, dir_left, dir_right, input ready);
  modport sink (input valid, duty_left, duty_right, dir_left, dir_right, output ready);
endinterface

// File: hw/rtl/jdm_front.sv
// ----------------------------------------------------------------------------
// jdm_front: command classifier
// Accepts a command request, sorts the position into a drive region and
// forms the operands that the back end needs for that region.
// ----------------------------------------------------------------------------
module jdm_front (
  jdm_cmd_if.sink         command,
  input  logic            full,
  output logic            push,
  output jdm_pkg::job_t   job
);

  logic [jdm_pkg::COORD_W-1:0] sx;
  logic [jdm_pkg::COORD_W-1:0] sy;
  logic [jdm_pkg::COORD_W:0]   xy_sum;
  logic [jdm_pkg::VAL_W-1:0]   xv;
  logic [jdm_pkg::VAL_W-1:0]   yv;
  logic                        centre;
  logic                        x_band;
  logic                        y_band;
  logic                        spin_ok;

  // A request is taken whenever the queue has room.
  assign command.ready = !full;
  assign push          = command.valid && !full;

  assign sx     = command.stick_x;
  assign sy     = command.stick_y;
  assign xy_sum = {1'b0, sx} + {1'b0, sy};
  assign xv     = jdm_pkg::VAL_W'(sx);
  assign yv     = jdm_pkg::VAL_W'(sy);

  // Region tests on the dead band.
  assign centre = sx < jdm_pkg::DEAD_HI && sy < jdm_pkg::DEAD_HI &&
                  sx > jdm_pkg::DEAD_LO && sy > jdm_pkg::DEAD_LO;
  assign x_band = sx <= jdm_pkg::DEAD_HI && sx >= jdm_pkg::DEAD_LO;
  assign y_band = sy > jdm_pkg::DEAD_LO && sy < jdm_pkg::DEAD_HI;
  assign spin_ok = command.spin_mode == jdm_pkg::MODE_SPIN_LEFT ||
                   command.spin_mode == jdm_pkg::MODE_STOP ||
                   command.spin_mode == jdm_pkg::MODE_SPIN_RIGHT;

  // Region priority: centre, straight directions, then the four corners.
  always_comb begin
    job       = '0;
    job.kind  = jdm_pkg::KIND_HOLD;
    job.speed = command.speed;
    job.vy    = yv - jdm_pkg::VAL_W'(jdm_pkg::CENTRE);
    if (centre && spin_ok) begin
      job.kind  = jdm_pkg::KIND_MIX;
      if (command.spin_mode != jdm_pkg::MODE_STOP) begin
        job.op_a0 = jdm_pkg::VAL_W'(jdm_pkg::CENTRE);
        job.op_a1 = jdm_pkg::VAL_W'(jdm_pkg::CENTRE);
      end
      job.dir_l = command.spin_mode == jdm_pkg::MODE_SPIN_LEFT;
      job.dir_r = command.spin_mode == jdm_pkg::MODE_SPIN_RIGHT;
    end else if (x_band && sy >= jdm_pkg::DEAD_HI) begin
      job.kind  = jdm_pkg::KIND_MIX;
      job.op_a0 = yv - jdm_pkg::VAL_W'(jdm_pkg::CENTRE);
      job.op_a1 = yv - jdm_pkg::VAL_W'(jdm_pkg::CENTRE);
    end else if (x_band && sy <= jdm_pkg::DEAD_LO) begin
      job.kind  = jdm_pkg::KIND_MIX;
      job.op_a0 = jdm_pkg::VAL_W'(jdm_pkg::CENTRE) - yv;
      job.op_a1 = jdm_pkg::VAL_W'(jdm_pkg::CENTRE) - yv;
      job.dir_l = 1'b1;
      job.dir_r = 1'b1;
    end else if (y_band && sx < jdm_pkg::DEAD_LO) begin
      job.kind  = jdm_pkg::KIND_MIX;
      job.op_a1 = jdm_pkg::VAL_W'(jdm_pkg::CENTRE) - xv;
    end else if (y_band && sx > jdm_pkg::DEAD_HI) begin
      job.kind  = jdm_pkg::KIND_MIX;
      job.op_a0 = xv - jdm_pkg::VAL_W'(jdm_pkg::CENTRE);
    end else if (sx > jdm_pkg::DEAD_HI && sy >= jdm_pkg::DEAD_HI) begin
      // Upper right corner.
      if (sy >= sx) begin
        job.kind  = jdm_pkg::KIND_TR_A;
        job.op_a0 = xv - jdm_pkg::VAL_W'(jdm_pkg::REMAP_LO);
        job.base  = yv - jdm_pkg::VAL_W'(jdm_pkg::REMAP_LO);
      end else begin
        job.kind  = jdm_pkg::KIND_TR_B;
        // On the dead-band edge the remap quotient truncates to zero.
        if (sy > jdm_pkg::DEAD_HI) begin
          job.op_a0 = yv - jdm_pkg::VAL_W'(jdm_pkg::REMAP_LO);
        end
        job.op_a1 = xv - jdm_pkg::VAL_W'(jdm_pkg::REMAP_LO);
      end
    end else if (sx < jdm_pkg::DEAD_LO && sy > jdm_pkg::DEAD_HI) begin
      // Upper left corner, x mirrored about the full scale.
      if (xy_sum > jdm_pkg::FULL) begin
        job.kind  = jdm_pkg::KIND_TL_A;
        job.op_a0 = xv;
        job.base  = yv - jdm_pkg::VAL_W'(jdm_pkg::X_TOP_A);
      end else begin
        job.kind  = jdm_pkg::KIND_TL_B;
        job.op_a0 = jdm_pkg::VAL_W'(jdm_pkg::FULL) - yv;
        job.op_a1 = jdm_pkg::VAL_W'(jdm_pkg::DEAD_LO) - xv;
      end
    end else if (sx < jdm_pkg::DEAD_LO && sy < jdm_pkg::DEAD_LO) begin
      // Lower left corner: both axes mirrored.
      job.kind  = jdm_pkg::KIND_MIX;
      job.dir_l = 1'b1;
      job.dir_r = 1'b1;
      if (sy <= sx) begin
        job.op_a0 = jdm_pkg::VAL_W'(jdm_pkg::CENTRE) - yv;
        job.op_a1 = xv - yv;
      end
    end else if (sx > jdm_pkg::DEAD_HI && sy < jdm_pkg::DEAD_LO) begin
      // Lower right corner: y mirrored.
      job.kind  = jdm_pkg::KIND_MIX;
      job.dir_l = 1'b1;
      job.dir_r = 1'b1;
      if (xy_sum <= jdm_pkg::FULL) begin
        job.op_a0 = jdm_pkg::VAL_W'(jdm_pkg::FULL) - yv - xv;
        job.op_a1 = jdm_pkg::VAL_W'(jdm_pkg::CENTRE) - yv;
      end
    end
  end

endmodule

// File: hw/rtl/jdm_queue.sv
// ----------------------------------------------------------------------------
// jdm_queue: job queue
// Small circular buffer of classified jobs between the front and back ends.
// ----------------------------------------------------------------------------
module jdm_queue #(
  parameter int DEPTH = jdm_pkg::QUEUE_DEPTH
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  jdm_pkg::job_t wr_data,
  output logic          full,
  input  logic          pop,
  output logic          empty,
  output jdm_pkg::job_t rd_data
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  jdm_pkg::job_t    entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full    = count == CNT_W'(DEPTH);
  assign empty   = count == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rd_data = entries[rd_ptr];

  // Storage write.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_data;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// File: hw/rtl/jdm_muldiv.sv
// ----------------------------------------------------------------------------
// jdm_muldiv: multiply and divide by a constant
// Computes (a * b) / d for d of 25, 819 or 820 in four pipelined steps:
// product, reciprocal multiply, back-multiply, and a one-step correction.
// ----------------------------------------------------------------------------
module jdm_muldiv (
  input  logic             clk,
  input  logic             rst,
  input  jdm_pkg::md_req_t req,
  output jdm_pkg::md_rsp_t rsp
);

  logic [jdm_pkg::P_W-1:0]      p;
  logic [jdm_pkg::T_W-1:0]      t;
  logic [jdm_pkg::Q_W-1:0]      q_est;
  logic [jdm_pkg::P_W-1:0]      back;
  logic [jdm_pkg::P_W-1:0]      rem;
  logic [jdm_pkg::DIVSEL_W-1:0] sel;
  logic [jdm_pkg::DIV_W-1:0]    d;
  logic                         v1;
  logic                         v2;
  logic                         v3;
  logic                         done;
  logic [jdm_pkg::Q_W-1:0]      quot;

  assign d   = jdm_pkg::div_const(sel);
  assign rem = p - back;
  assign rsp = '{done: done, q: quot};

  // Step valids and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      v1   <= req.start;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  // The estimate from the truncated reciprocal is low by at most one.
  always_ff @(posedge clk) begin
    if (req.start) begin
      p   <= jdm_pkg::P_W'(req.a) * jdm_pkg::P_W'(req.b);
      sel <= req.sel;
    end
    if (v1) begin
      t <= jdm_pkg::T_W'(p) * jdm_pkg::T_W'(jdm_pkg::recip_const(sel));
    end
    if (v2) begin
      q_est <= t[jdm_pkg::T_W-1:jdm_pkg::RECIP_SHIFT];
      back  <= jdm_pkg::P_W'(t[jdm_pkg::T_W-1:jdm_pkg::RECIP_SHIFT]) * jdm_pkg::P_W'(d);
    end
    if (v3) begin
      quot <= q_est + jdm_pkg::Q_W'(rem >= jdm_pkg::P_W'(d));
    end
  end

endmodule

// File: hw/rtl/jdm_back.sv
// ----------------------------------------------------------------------------
// jdm_back: drive sequencer
// Pops classified jobs, runs the corner remaps and duty scaling through the
// shared multiply-divide unit, and holds the drive request for the sink.
// ----------------------------------------------------------------------------
module jdm_back (
  input  logic              clk,
  input  logic              rst,
  input  jdm_pkg::job_t     job,
  input  logic              empty,
  output logic              pop,
  output jdm_pkg::md_req_t  md_req,
  input  jdm_pkg::md_rsp_t  md_rsp,
  jdm_drv_if.source         motor
);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REMAP1 = 3'd1;
  localparam logic [2:0] ST_REMAP2 = 3'd2;
  localparam logic [2:0] ST_FIX    = 3'd3;
  localparam logic [2:0] ST_LEFT   = 3'd4;
  localparam logic [2:0] ST_RIGHT  = 3'd5;
  localparam logic [2:0] ST_OUT    = 3'd6;

  logic [2:0]                   state;
  jdm_pkg::job_t                cur;
  logic [jdm_pkg::VAL_W-1:0]    q1;
  logic [jdm_pkg::VAL_W-1:0]    q2;
  logic [jdm_pkg::VAL_W-1:0]    vr;
  logic [jdm_pkg::DUTY_W-1:0]   res_l;
  logic [jdm_pkg::DUTY_W-1:0]   res_r;
  logic                         res_dl;
  logic                         res_dr;
  logic                         out_valid;
  logic [jdm_pkg::DUTY_W-1:0]   held_l;
  logic [jdm_pkg::DUTY_W-1:0]   held_r;
  logic                         held_dl;
  logic                         held_dr;
  logic                         slot_free;
  logic [jdm_pkg::MUL_B_W-1:0]  r1_b;
  logic [jdm_pkg::DIVSEL_W-1:0] r1_sel;
  logic [jdm_pkg::VAL_W-1:0]    q_sum;
  logic [jdm_pkg::VAL_W-1:0]    fix_l;
  logic [jdm_pkg::VAL_W-1:0]    fix_r;
  logic                         fix_hold;

  assign slot_free = !out_valid || motor.ready;
  assign pop       = (state == ST_IDLE) && !empty;

  assign motor.valid      = out_valid;
  assign motor.duty_left  = held_l;
  assign motor.duty_right = held_r;
  assign motor.dir_left   = held_dl;
  assign motor.dir_right  = held_dr;

  // Slope and divisor of the first remap, chosen from the job at the queue head.
  always_comb begin
    case (job.kind)
      jdm_pkg::KIND_TR_A: begin
        r1_b   = jdm_pkg::MUL_B_W'(jdm_pkg::SLOPE_A);
        r1_sel = jdm_pkg::DIV_BY_819;
      end
      jdm_pkg::KIND_TL_A: begin
        r1_b   = jdm_pkg::MUL_B_W'(jdm_pkg::SLOPE_A);
        r1_sel = jdm_pkg::DIV_BY_820;
      end
      default: begin
        r1_b   = jdm_pkg::MUL_B_W'(jdm_pkg::SLOPE_B);
        r1_sel = jdm_pkg::DIV_BY_819;
      end
    endcase
  end

  // Duty operands of a corner, formed from the remap quotients.
  assign q_sum = q1 + q2;
  always_comb begin
    fix_hold = 1'b0;
    case (cur.kind)
      jdm_pkg::KIND_TR_A: begin
        fix_l = cur.vy;
        fix_r = cur.base - q1;
      end
      jdm_pkg::KIND_TL_A: begin
        fix_l = cur.base + q1;
        fix_r = cur.vy;
      end
      jdm_pkg::KIND_TR_B: begin
        // A negative difference leaves the outputs as they were.
        fix_hold = q_sum < jdm_pkg::VAL_W'(jdm_pkg::SLOPE_B);
        fix_l    = jdm_pkg::VAL_W'(jdm_pkg::NX_OFFSET) + q2;
        fix_r    = q_sum - jdm_pkg::VAL_W'(jdm_pkg::SLOPE_B);
      end
      jdm_pkg::KIND_TL_B: begin
        fix_hold = q2 < q1;
        fix_l    = q2 - q1;
        fix_r    = jdm_pkg::VAL_W'(jdm_pkg::NX_OFFSET) + q2;
      end
      default: begin
        fix_l = cur.op_a0;
        fix_r = cur.op_a1;
      end
    endcase
  end

  // Sequencer, unit requests and the output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      md_req    <= '0;
      out_valid <= 1'b0;
      held_l    <= '0;
      held_r    <= '0;
      held_dl   <= 1'b0;
      held_dr   <= 1'b0;
    end else begin
      md_req.start <= 1'b0;
      if (out_valid && motor.ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (!empty) begin
            cur    <= job;
            res_dl <= job.dir_l;
            res_dr <= job.dir_r;
            if (job.kind == jdm_pkg::KIND_HOLD) begin
              res_l  <= held_l;
              res_r  <= held_r;
              res_dl <= held_dl;
              res_dr <= held_dr;
              state  <= ST_OUT;
            end else if (job.kind == jdm_pkg::KIND_MIX) begin
              md_req <= '{start: 1'b1, a: job.op_a0,
                          b: jdm_pkg::MUL_B_W'(job.speed), sel: jdm_pkg::DIV_BY_25};
              vr     <= job.op_a1;
              state  <= ST_LEFT;
            end else begin
              md_req <= '{start: 1'b1, a: job.op_a0, b: r1_b, sel: r1_sel};
              state  <= ST_REMAP1;
            end
          end
        end
        ST_REMAP1: begin
          if (md_rsp.done) begin
            q1 <= jdm_pkg::VAL_W'(md_rsp.q);
            if (cur.kind == jdm_pkg::KIND_TR_B || cur.kind == jdm_pkg::KIND_TL_B) begin
              md_req <= '{start: 1'b1, a: cur.op_a1,
                          b: jdm_pkg::MUL_B_W'(jdm_pkg::SLOPE_B), sel: jdm_pkg::DIV_BY_819};
              state  <= ST_REMAP2;
            end else begin
              q2    <= '0;
              state <= ST_FIX;
            end
          end
        end
        ST_REMAP2: begin
          if (md_rsp.done) begin
            q2    <= jdm_pkg::VAL_W'(md_rsp.q);
            state <= ST_FIX;
          end
        end
        ST_FIX: begin
          if (fix_hold) begin
            res_l  <= held_l;
            res_r  <= held_r;
            res_dl <= held_dl;
            res_dr <= held_dr;
            state  <= ST_OUT;
          end else begin
            md_req <= '{start: 1'b1, a: fix_l,
                        b: jdm_pkg::MUL_B_W'(cur.speed), sel: jdm_pkg::DIV_BY_25};
            vr     <= fix_r;
            state  <= ST_LEFT;
          end
        end
        ST_LEFT: begin
          if (md_rsp.done) begin
            res_l  <= md_rsp.q[jdm_pkg::DUTY_W-1:0];
            md_req <= '{start: 1'b1, a: vr,
                        b: jdm_pkg::MUL_B_W'(cur.speed), sel: jdm_pkg::DIV_BY_25};
            state  <= ST_RIGHT;
          end
        end
        ST_RIGHT: begin
          if (md_rsp.done) begin
            res_r <= md_rsp.q[jdm_pkg::DUTY_W-1:0];
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          // The output register doubles as the held drive state.
          if (slot_free) begin
            out_valid <= 1'b1;
            held_l    <= res_l;
            held_r    <= res_r;
            held_dl   <= res_dl;
            held_dr   <= res_dr;
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: hw/rtl/joystick_diff_drive_mixer.sv
// ----------------------------------------------------------------------------
// joystick_diff_drive_mixer: joystick to differential-drive mixer
// Turns one joystick command into a pair of motor duties and directions.
// ----------------------------------------------------------------------------
// Each command request yields exactly one drive request, in order. Commands
// are classified on entry and queued, so new commands are taken while an
// earlier one is still being worked or its drive request still waits. Every
// duty is a product scaled by a constant divisor, computed in a shared
// four-step multiply-divide unit, and the items pass through it one at a
// time. A command in the centre with an unused spin mode, or on a dead-band
// edge, repeats the last drive values. Centre spins, straight directions and
// the lower corners take two unit operations. The upper corners run one or
// two remaps before those; an upper corner whose remapped difference is
// negative, which only happens on the two-remap branches, repeats the last
// drive values. A stalled sink holds back the drive request.
module joystick_diff_drive_mixer #(
  parameter int QUEUE_DEPTH = jdm_pkg::QUEUE_DEPTH
) (
  input  logic       clk,
  input  logic       rst,
  jdm_cmd_if.sink    command,
  jdm_drv_if.source  motor
);

  jdm_pkg::job_t    front_job;
  jdm_pkg::job_t    head_job;
  logic             push;
  logic             full;
  logic             pop;
  logic             empty;
  jdm_pkg::md_req_t md_req;
  jdm_pkg::md_rsp_t md_rsp;

  // Classifier on the command side.
  jdm_front u_front (
    .command (command),
    .full    (full),
    .push    (push),
    .job     (front_job)
  );

  // Decoupling queue.
  jdm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (front_job),
    .full    (full),
    .pop     (pop),
    .empty   (empty),
    .rd_data (head_job)
  );

  // Shared arithmetic unit.
  jdm_muldiv u_muldiv (
    .clk (clk),
    .rst (rst),
    .req (md_req),
    .rsp (md_rsp)
  );

  // Sequencer on the drive side.
  jdm_back u_back (
    .clk    (clk),
    .rst    (rst),
    .job    (head_job),
    .empty  (empty),
    .pop    (pop),
    .md_req (md_req),
    .md_rsp (md_rsp),
    .motor  (motor)
  );

endmodule
